@@ design/lgd_pkg.sv @@
// shared types, command codes and the sine brightness table of the led grid dimmer
package lgd_pkg;

  localparam int unsigned LED_COUNT  = 64;
  localparam int unsigned LED_AW     = 6;
  localparam int unsigned MAX_SIDE   = 8;
  localparam int unsigned SINE_DEPTH = 256;
  localparam int unsigned SINE_AW    = 8;

  localparam logic [15:0] PERIOD_RESET = 16'd1000;
  localparam logic [3:0]  SIDE_RESET   = 4'd8;

  typedef enum logic [2:0] {
    FN_SET_COLOR  = 3'd0,
    FN_SET_LEVEL  = 3'd1,
    FN_SET_MONO   = 3'd2,
    FN_ALL_MONO   = 3'd3,
    FN_REFRESH    = 3'd4,
    FN_PULSE      = 3'd5,
    FN_TICK       = 3'd6,
    FN_NOP        = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_PERIOD = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_e;

  typedef logic [7:0] sine_lut_t [SINE_DEPTH];

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // quarter-wave reduction, then taylor terms to x^9 in q2.30
  function automatic sine_lut_t build_sine();
    sine_lut_t       lut;
    longint unsigned t, f, x, x2, a, b, c, d, s;
    int unsigned     quad;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      t    = (longint'(i) << 32) / SINE_DEPTH;
      quad = int'((t >> 30) & 64'd3);
      f    = t & (Q30_ONE - 64'd1);
      if (quad[0]) f = Q30_ONE - f;
      x  = (f * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      a  = Q30_ONE - x2 / 72;
      b  = Q30_ONE - ((x2 * a) >> 30) / 42;
      c  = Q30_ONE - ((x2 * b) >> 30) / 20;
      d  = Q30_ONE - ((x2 * c) >> 30) / 6;
      s  = (x * d) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      if (quad < 2) lut[i] = 8'(64'd127 + ((s * 64'd127) >> 30));
      else          lut[i] = 8'(((Q30_ONE - s) * 64'd127) >> 30);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage

@@ design/led_grid_dimmer_rainbow_pulse_top.sv @@
// led grid frame buffer with per-led dimming, mono levels and a rainbow sine pulse
// Single-entry commands (set colour, brightness, mono level, start pulse) leave the
// block ready in the next cycle. Set-all-mono sweeps the 64 brightness entries, one per
// cycle. A refresh walks the n = rows*columns pixels, each through a memory read, a
// dimming multiply and an output load. A tick with a pulse running first runs the shared
// 32-step restoring divider twice (pulse progress, then the per-diagonal hue step), then
// takes each pixel through hue add, hsv segment, dimming multiply and output load.
// Results leave through an output register, so a waiting result stalls only the walk.
// Storage resets through per-entry valid bits; there is no clearing pass after reset.
module led_grid_dimmer_rainbow_pulse_top
  import lgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [2:0]  col_x_i,
  input  logic [2:0]  row_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  level_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  pixel_index_o,
  output logic [23:0] pixel_color_o,
  output logic        last_pixel_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CLR  = 8'b0000_0010,
    ST_DIV  = 8'b0000_0100,
    ST_HUE  = 8'b0000_1000,
    ST_COL  = 8'b0001_0000,
    ST_RD   = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  state_e state_q;

  logic [3:0]  rows_q, cols_q;
  logic [15:0] period_q;
  logic        active_q;
  logic [31:0] start_q;

  logic [23:0] col_mem [LED_COUNT];
  logic [7:0]  lvl_mem [LED_COUNT];
  logic [LED_COUNT-1:0] col_vld_q, lvl_vld_q;
  logic [23:0] rd_col_q;
  logic [7:0]  rd_lvl_q;

  logic        col_we, lvl_we;
  logic [LED_AW-1:0] col_wa, lvl_wa;
  logic [23:0] col_wd;
  logic [7:0]  lvl_wd;

  logic [LED_AW-1:0] idx_q, clr_idx_q;
  logic [7:0]  mono_q;
  logic        tick_q, div_sel_q;

  // shared divider
  logic [16:0] div_rem_q;
  logic [31:0] div_dvd_q;
  logic [15:0] div_dsr_q;
  logic [4:0]  div_cnt_q;
  logic [16:0] div_sh;
  logic        div_ge;
  logic [15:0] div_quo, prog_quo;

  logic [15:0] progress_q, step_q, row_hq, pix_hq;
  logic [4:0]  step_r_q, row_r_q, pix_r_q;
  logic [7:0]  sine_q;
  logic [2:0]  x_q;
  logic [16:0] hue_q;
  logic [23:0] pix_rgb_q;
  logic [15:0] prod_r_q, prod_g_q, prod_b_q;

  logic        out_valid_q, last_q;
  logic [5:0]  out_idx_q;
  logic [23:0] out_col_q;

  // derived grid values
  logic [3:0]  rows_eff, cols_eff;
  logic [4:0]  dsum;
  logic [6:0]  n_pix, lin;
  logic        in_grid, is_last, in_fire, out_free, x_wrap;
  logic [LED_AW-1:0] addr;
  logic [31:0] elapsed;
  logic        el_wrap;
  logic [7:0]  mono;

  assign rows_eff = (rows_q > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : rows_q;
  assign cols_eff = (cols_q > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : cols_q;
  assign dsum     = {1'b0, rows_eff} + {1'b0, cols_eff};
  assign n_pix    = 7'(rows_eff) * 7'(cols_eff);
  assign in_grid  = ({1'b0, col_x_i} < cols_eff) && ({1'b0, row_y_i} < rows_eff);
  assign lin      = 7'(row_y_i) * 7'(cols_eff) + 7'(col_x_i);
  assign addr     = in_grid ? lin[LED_AW-1:0] : '0;
  assign is_last  = (7'(idx_q) + 7'd1) == n_pix;
  assign x_wrap   = ({1'b0, x_q} + 4'd1) == cols_eff;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign elapsed  = time_ms_i - start_q;
  assign el_wrap  = elapsed >= {16'b0, period_q};
  assign mono     = 8'({level_i, 4'b0} + {4'b0, level_i});

  assign div_sh = {div_rem_q[15:0], div_dvd_q[31]};
  assign div_ge = div_sh >= {1'b0, div_dsr_q};
  assign div_quo = {div_dvd_q[14:0], div_ge};
  // a zero period gives zero progress
  assign prog_quo = (period_q == 16'd0) ? 16'd0 : div_quo;

  // hue quotient and remainder advanced by one diagonal step
  function automatic logic [20:0] hue_adv(input logic [15:0] q, input logic [4:0] r,
                                          input logic [15:0] sq, input logic [4:0] sr,
                                          input logic [4:0] dv);
    logic [5:0]  rs;
    logic [15:0] qn;
    rs = {1'b0, r} + {1'b0, sr};
    qn = q + sq;
    if (rs >= {1'b0, dv}) begin
      rs = rs - {1'b0, dv};
      qn = qn + 16'd1;
    end
    return {qn, rs[4:0]};
  endfunction

  logic [20:0] pix_next, row_next;
  assign pix_next = hue_adv(pix_hq, pix_r_q, step_q, step_r_q, dsum);
  assign row_next = hue_adv(row_hq, row_r_q, step_q, step_r_q, dsum);

  // hsv segment
  logic [18:0] h6;
  logic [15:0] frac;
  logic [16:0] fall_in;
  logic [24:0] rise_p, fall_p;
  logic [7:0]  rise, fall;
  logic [23:0] hsv_rgb;

  assign h6      = {hue_q, 2'b0} + {1'b0, hue_q, 1'b0};
  assign frac    = h6[15:0];
  assign fall_in = 17'h10000 - {1'b0, frac};
  assign rise_p  = {1'b0, frac, 8'b0} - {9'b0, frac};
  assign fall_p  = {fall_in, 8'b0} - {8'b0, fall_in};
  assign rise    = rise_p[23:16];
  assign fall    = fall_p[23:16];

  always_comb begin
    case (h6[18:16])
      3'd0:    hsv_rgb = {8'hFF, rise, 8'h00};
      3'd1:    hsv_rgb = {fall, 8'hFF, 8'h00};
      3'd2:    hsv_rgb = {8'h00, 8'hFF, rise};
      3'd3:    hsv_rgb = {8'h00, fall, 8'hFF};
      3'd4:    hsv_rgb = {rise, 8'h00, 8'hFF};
      3'd5:    hsv_rgb = {8'hFF, 8'h00, fall};
      default: hsv_rgb = {8'hFF, 8'h00, 8'h00};
    endcase
  end

  // dimming sources and divide by 255
  logic [23:0] src_rgb;
  logic [7:0]  src_lvl;
  assign src_rgb = tick_q ? pix_rgb_q : (col_vld_q[idx_q] ? rd_col_q : 24'hFF_FFFF);
  assign src_lvl = tick_q ? sine_q : (lvl_vld_q[idx_q] ? rd_lvl_q : 8'h00);

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // memory write port selection
  always_comb begin
    col_we = 1'b0;
    col_wa = idx_q;
    col_wd = hsv_rgb;
    lvl_we = 1'b0;
    lvl_wa = idx_q;
    lvl_wd = sine_q;
    unique case (state_q)
      ST_IDLE: begin
        col_wa = addr;
        col_wd = {red_i, green_i, blue_i};
        lvl_wa = addr;
        lvl_wd = (func_e'(func_i) == FN_SET_MONO) ? mono : level_i;
        col_we = in_fire && (func_e'(func_i) == FN_SET_COLOR);
        lvl_we = in_fire && ((func_e'(func_i) == FN_SET_LEVEL) ||
                             (func_e'(func_i) == FN_SET_MONO));
      end
      ST_CLR: begin
        lvl_we = 1'b1;
        lvl_wa = clr_idx_q;
        lvl_wd = mono_q;
      end
      ST_COL: begin
        col_we = 1'b1;
        lvl_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    if (state_q == ST_RD) begin
      rd_col_q <= col_mem[idx_q];
      rd_lvl_q <= lvl_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= '0;
      lvl_vld_q <= '0;
    end else begin
      if (col_we) col_vld_q[col_wa] <= 1'b1;
      if (lvl_we) lvl_vld_q[lvl_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= SIDE_RESET;
      cols_q   <= SIDE_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_ROWS:   rows_q   <= cfg_data_i[3:0];
        CFG_COLS:   cols_q   <= cfg_data_i[3:0];
        CFG_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // payload registers of the walk
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        mono_q <= mono;
        div_rem_q <= '0;
        div_cnt_q <= '0;
        div_dsr_q <= period_q;
        div_dvd_q <= el_wrap ? 32'd0 : {elapsed[15:0], 16'b0};
        idx_q     <= '0;
      end
      ST_DIV: begin
        div_cnt_q <= div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd31 && !div_sel_q) begin
          progress_q <= prog_quo;
          sine_q     <= SINE_LUT[prog_quo[15:16-SINE_AW]];
          div_rem_q  <= '0;
          div_dvd_q  <= 32'h0001_0000;
          div_dsr_q  <= {11'b0, dsum};
        end else begin
          div_rem_q <= div_ge ? div_sh - {1'b0, div_dsr_q} : div_sh;
          div_dvd_q <= {div_dvd_q[30:0], div_ge};
        end
        if (div_cnt_q == 5'd31 && div_sel_q) begin
          step_q   <= div_quo;
          step_r_q <= div_ge ? 5'(div_sh - {1'b0, div_dsr_q}) : div_sh[4:0];
          row_hq   <= '0;
          row_r_q  <= '0;
          pix_hq   <= '0;
          pix_r_q  <= '0;
          x_q      <= '0;
        end
      end
      ST_HUE: begin
        hue_q <= ({1'b0, pix_hq} + {1'b0, progress_q} > 17'h10000) ?
                 {1'b0, pix_hq} + {1'b0, progress_q} - 17'h10000 :
                 {1'b0, pix_hq} + {1'b0, progress_q};
      end
      ST_COL: pix_rgb_q <= hsv_rgb;
      ST_MUL: begin
        prod_r_q <= src_lvl * src_rgb[23:16];
        prod_g_q <= src_lvl * src_rgb[15:8];
        prod_b_q <= src_lvl * src_rgb[7:0];
      end
      ST_EMIT: begin
        if (out_free && !is_last) begin
          idx_q <= idx_q + 6'd1;
          if (x_wrap) begin
            x_q     <= '0;
            row_hq  <= row_next[20:5];
            row_r_q <= row_next[4:0];
            pix_hq  <= row_next[20:5];
            pix_r_q <= row_next[4:0];
          end else begin
            x_q     <= x_q + 3'd1;
            pix_hq  <= pix_next[20:5];
            pix_r_q <= pix_next[4:0];
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer and pulse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= 1'b0;
      start_q   <= '0;
      tick_q    <= 1'b0;
      div_sel_q <= 1'b0;
      clr_idx_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (func_e'(func_i))
              FN_ALL_MONO: begin
                clr_idx_q <= '0;
                state_q   <= ST_CLR;
              end
              FN_REFRESH: begin
                tick_q <= 1'b0;
                if (n_pix != 7'd0) state_q <= ST_RD;
              end
              FN_PULSE: begin
                active_q <= 1'b1;
                start_q  <= time_ms_i;
              end
              FN_TICK: begin
                if (active_q) begin
                  if (el_wrap) start_q <= time_ms_i;
                  tick_q    <= 1'b1;
                  div_sel_q <= 1'b0;
                  state_q   <= ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CLR: begin
          clr_idx_q <= clr_idx_q + 6'd1;
          if (clr_idx_q == LED_AW'(LED_COUNT - 1)) state_q <= ST_IDLE;
        end
        ST_DIV: begin
          if (div_cnt_q == 5'd31) begin
            if (!div_sel_q) begin
              div_sel_q <= 1'b1;
              if (n_pix == 7'd0) state_q <= ST_IDLE;
            end else begin
              state_q <= ST_HUE;
            end
          end
        end
        ST_HUE:  state_q <= ST_COL;
        ST_COL:  state_q <= ST_MUL;
        ST_RD:   state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            if (is_last)     state_q <= ST_IDLE;
            else if (tick_q) state_q <= ST_HUE;
            else             state_q <= ST_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_idx_q <= idx_q;
      out_col_q <= {div255(prod_r_q), div255(prod_g_q), div255(prod_b_q)};
      last_q    <= is_last;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign pixel_color_o = out_col_q;
  assign last_pixel_o  = last_q;

endmodule

@@ design/lgd_checker.sv @@
// port-level checks of the led grid dimmer, bound to its top level
module lgd_checker
  import lgd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  func_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  pixel_index_o,
  input logic [23:0] pixel_color_o,
  input logic        last_pixel_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_color_o) &&
                                    $stable(pixel_index_o) && $stable(last_pixel_o))
    else $error("stalled result changed");

  // a waiting pixel that is not the last one means the walk is still running
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pixel_o |-> !in_ready_o)
    else $error("ready while a refresh is unfinished");

  // the brightness sweep always takes the block away
  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FN_ALL_MONO |=> !in_ready_o)
    else $error("set-all-mono did not sweep");

  // single-entry writes leave the block ready in the next cycle
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FN_SET_COLOR || func_i == FN_SET_LEVEL ||
                                 func_i == FN_SET_MONO || func_i == FN_PULSE)
    |=> in_ready_o)
    else $error("single write held the block");

endmodule

bind led_grid_dimmer_rainbow_pulse_top lgd_checker u_lgd_checker (.*);

@@ verif/led_grid_dimmer_rainbow_pulse_top_tb.sv @@
// self-checking testbench for the led grid dimmer with rainbow sine pulse
`timescale 1ns / 1ps

module led_grid_dimmer_rainbow_pulse_top_tb;
  import lgd_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct {
    func_e       fn;
    logic [2:0]  col;
    logic [2:0]  row;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  lvl;
    logic [31:0] ms;
    bit          has_exp;
    logic [23:0] exp_color;
  } cmd_t;

  typedef struct {
    logic [5:0]  idx;
    logic [23:0] color;
    logic        last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_ROWS;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = FN_NOP;
  logic [2:0]  col_x_i = '0;
  logic [2:0]  row_y_i = '0;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic [7:0]  level_i = '0;
  logic [31:0] time_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  pixel_index_o;
  logic [23:0] pixel_color_o;
  logic        last_pixel_o;

  // shadow of the frame buffer and settings
  logic [7:0]  fb_red [LED_COUNT];
  logic [7:0]  fb_green [LED_COUNT];
  logic [7:0]  fb_blue [LED_COUNT];
  logic [7:0]  fb_level [LED_COUNT];
  logic [7:0]  sine_tab [SINE_DEPTH];
  bit          pulse_on;
  logic [31:0] pulse_t0;
  logic [3:0]  rows_reg;
  logic [3:0]  cols_reg;
  logic [15:0] period_reg;

  pixel_t      pixel_q [$];
  int          fail_cnt = 0;
  int          items_sent = 0;
  int          pixels_seen = 0;
  int          burst_left = 0;
  logic [31:0] now_ms = 0;

  led_grid_dimmer_rainbow_pulse_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout at %0t", $time);
    $display("led_grid_dimmer_rainbow_pulse_top_tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] sine_entry(int unsigned i);
    longint unsigned one, hp, t, f, x, x2, a, b, c, d, s;
    int unsigned     quad;
    one = 64'd1073741824;
    hp  = 64'd1686629713;
    t = (64'(i) << 32) / SINE_DEPTH;
    quad = int'((t >> 30) & 3);
    f = t & (one - 1);
    if (quad % 2 == 1) f = one - f;
    x  = (f * hp) >> 30;
    x2 = (x * x) >> 30;
    a  = one - x2 / 72;
    b  = one - ((x2 * a) >> 30) / 42;
    c  = one - ((x2 * b) >> 30) / 20;
    d  = one - ((x2 * c) >> 30) / 6;
    s  = (x * d) >> 30;
    if (s > one) s = one;
    if (quad < 2) return 8'(127 + ((s * 127) >> 30));
    return 8'(((one - s) * 127) >> 30);
  endfunction

  function automatic int unsigned used_rows();
    return (rows_reg > MAX_SIDE) ? MAX_SIDE : rows_reg;
  endfunction

  function automatic int unsigned used_cols();
    return (cols_reg > MAX_SIDE) ? MAX_SIDE : cols_reg;
  endfunction

  function automatic void frame_reset();
    for (int i = 0; i < LED_COUNT; i++) begin
      fb_red[i] = 8'hFF; fb_green[i] = 8'hFF; fb_blue[i] = 8'hFF; fb_level[i] = 8'h00;
    end
    for (int i = 0; i < SINE_DEPTH; i++) sine_tab[i] = sine_entry(i);
    pulse_on = 1'b0;
    pulse_t0 = '0;
    rows_reg = SIDE_RESET;
    cols_reg = SIDE_RESET;
    period_reg = PERIOD_RESET;
  endfunction

  // queue the dimmed pixels of one refresh in row-major order
  function automatic void queue_refresh();
    int unsigned nr, nc, idx, n;
    pixel_t      p;
    nr = used_rows();
    nc = used_cols();
    n = 0;
    for (int unsigned y = 0; y < nr; y++)
      for (int unsigned x = 0; x < nc; x++) begin
        idx = y * nc + x;
        if (idx < LED_COUNT) begin
          p.idx = 6'(idx);
          p.color = {8'(fb_level[idx] * fb_red[idx] / 255),
                     8'(fb_level[idx] * fb_green[idx] / 255),
                     8'(fb_level[idx] * fb_blue[idx] / 255)};
          p.last = 1'b0;
          pixel_q.push_back(p);
          n++;
        end
      end
    if (n > 0) pixel_q[pixel_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void paint_rainbow(logic [31:0] ms);
    logic [31:0] elapsed, progress, hue, h6;
    logic [7:0]  bright, cr, cg, cb;
    int unsigned nr, nc, idx;
    elapsed = ms - pulse_t0;
    if (elapsed >= period_reg) begin
      pulse_t0 = ms;
      elapsed = 0;
    end
    progress = (period_reg != 0) ? 32'((64'(elapsed) << 16) / period_reg) : 32'd0;
    bright = sine_tab[(64'(progress) * SINE_DEPTH) >> 16];
    nr = used_rows();
    nc = used_cols();
    for (int unsigned y = 0; y < nr; y++)
      for (int unsigned x = 0; x < nc; x++) begin
        idx = y * nc + x;
        if (idx < LED_COUNT) begin
          hue = 32'(((x + y) << 16) / (nc + nr)) + progress;
          if (hue > 32'd65536) hue -= 32'd65536;
          h6 = hue * 6;
          if (h6 < 32'd65536) begin
            cr = 255; cg = 8'((255 * h6) >> 16); cb = 0;
          end else if (h6 < 32'd131072) begin
            cr = 8'((255 * (32'd131072 - h6)) >> 16); cg = 255; cb = 0;
          end else if (h6 < 32'd196608) begin
            cr = 0; cg = 255; cb = 8'((255 * (h6 - 32'd131072)) >> 16);
          end else if (h6 < 32'd262144) begin
            cr = 0; cg = 8'((255 * (32'd262144 - h6)) >> 16); cb = 255;
          end else if (h6 < 32'd327680) begin
            cr = 8'((255 * (h6 - 32'd262144)) >> 16); cg = 0; cb = 255;
          end else begin
            cr = 255; cg = 0; cb = 8'((255 * (32'd393216 - h6)) >> 16);
          end
          fb_red[idx] = cr; fb_green[idx] = cg; fb_blue[idx] = cb;
          fb_level[idx] = bright;
        end
      end
  endfunction

  function automatic void apply_cmd(cmd_t c);
    int unsigned idx;
    logic [7:0]  mono;
    idx = (c.col < used_cols() && c.row < used_rows()) ? c.row * used_cols() + c.col : 0;
    mono = 8'(c.lvl * 17);
    case (c.fn)
      FN_SET_COLOR: if (idx < LED_COUNT) begin
        fb_red[idx] = c.r; fb_green[idx] = c.g; fb_blue[idx] = c.b;
      end
      FN_SET_LEVEL: if (idx < LED_COUNT) fb_level[idx] = c.lvl;
      FN_SET_MONO:  if (idx < LED_COUNT) fb_level[idx] = mono;
      FN_ALL_MONO:  for (int i = 0; i < LED_COUNT; i++) fb_level[i] = mono;
      FN_REFRESH:   queue_refresh();
      FN_PULSE: begin
        pulse_on = 1'b1;
        pulse_t0 = c.ms;
      end
      FN_TICK: if (pulse_on) begin
        paint_rainbow(c.ms);
        queue_refresh();
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(cmd_t c);
    int unsigned first;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i = 1'b1;
    func_i = c.fn; col_x_i = c.col; row_y_i = c.row;
    red_i = c.r; green_i = c.g; blue_i = c.b; level_i = c.lvl; time_ms_i = c.ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    first = pixel_q.size();
    apply_cmd(c);
    items_sent++;
    if (c.has_exp)
      for (int unsigned i = first; i < pixel_q.size(); i++)
        if (pixel_q[i].color !== c.exp_color) begin
          $display("%0t: pixel %0d expected color %h, predicted %h", $time,
                   pixel_q[i].idx, c.exp_color, pixel_q[i].color);
          fail_cnt++;
        end
  endtask

  task automatic write_reg(cfg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_ROWS:   rows_reg = data[3:0];
      CFG_COLS:   cols_reg = data[3:0];
      CFG_PERIOD: period_reg = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic cmd_t mk(func_e fn, int col, int row, logic [23:0] rgb, int lvl,
                              logic [31:0] ms, bit has_exp = 0, logic [23:0] exp_c = '0);
    cmd_t c;
    c.fn = fn; c.col = 3'(col); c.row = 3'(row);
    c.r = rgb[23:16]; c.g = rgb[15:8]; c.b = rgb[7:0];
    c.lvl = 8'(lvl); c.ms = ms; c.has_exp = has_exp; c.exp_color = exp_c;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick, span;
    pick = $urandom_range(0, 99);
    c = mk(FN_NOP, $urandom_range(0, 7), $urandom_range(0, 7), $urandom, $urandom, '0);
    // keep mostly inside the grid, otherwise any address
    if ($urandom_range(0, 3) != 0 && used_cols() > 0 && used_rows() > 0) begin
      c.col = 3'($urandom_range(0, used_cols() - 1));
      c.row = 3'($urandom_range(0, used_rows() - 1));
    end
    if      (pick < 18) c.fn = FN_SET_COLOR;
    else if (pick < 30) c.fn = FN_SET_LEVEL;
    else if (pick < 40) c.fn = FN_SET_MONO;
    else if (pick < 45) c.fn = FN_ALL_MONO;
    else if (pick < 62) c.fn = FN_REFRESH;
    else if (pick < 67) c.fn = FN_PULSE;
    else if (pick < 96) c.fn = FN_TICK;
    if ((c.fn == FN_SET_MONO || c.fn == FN_ALL_MONO) && $urandom_range(0, 3) != 0)
      c.lvl = 8'($urandom_range(0, 15));
    span = period_reg + period_reg / 4 + 2;
    if ($urandom_range(0, 9) == 0) now_ms = $urandom;
    else now_ms += $urandom_range(0, span);
    c.ms = now_ms;
    return c;
  endfunction

  // receiver: switches between always ready, random stalls and long stalls
  initial begin
    int mode, left;
    forever begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(20, 200);
      while (left > 0) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= ($urandom_range(0, 19) == 0);
        endcase
        left--;
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel idx %0d color %h last %b", $time,
                 pixel_index_o, pixel_color_o, last_pixel_o);
        fail_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_index_o !== want.idx) begin
          $display("%0t: pixel_index expected %0d actual %0d", $time, want.idx, pixel_index_o);
          fail_cnt++;
        end
        if (pixel_color_o !== want.color) begin
          $display("%0t: pixel_color expected %h actual %h", $time, want.color, pixel_color_o);
          fail_cnt++;
        end
        if (last_pixel_o !== want.last) begin
          $display("%0t: last_pixel expected %b actual %b", $time, want.last, last_pixel_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    cmd_t        dir_tab [$];
    logic [15:0] phase_cfg [10][3];
    frame_reset();
    phase_cfg = '{'{8, 8, 1000}, '{1, 1, 1}, '{8, 8, 65535}, '{3, 5, 7}, '{0, 4, 100},
                  '{15, 15, 0}, '{2, 8, 250}, '{8, 1, 37}, '{4, 0, 3}, '{8, 8, 500}};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_tab = '{
      mk(FN_REFRESH, 0, 0, 0, 0, 0, 1, 24'h000000),
      mk(FN_ALL_MONO, 0, 0, 0, 15, 0),
      mk(FN_REFRESH, 0, 0, 0, 0, 0, 1, 24'hFFFFFF),
      mk(FN_SET_COLOR, 7, 7, 24'h000000, 0, 0),
      mk(FN_SET_COLOR, 0, 0, 24'hFF8001, 0, 0),
      mk(FN_SET_COLOR, 3, 4, 24'h55AA7F, 0, 0),
      mk(FN_SET_LEVEL, 1, 0, 0, 8'h80, 0),
      mk(FN_SET_LEVEL, 7, 7, 0, 8'h00, 0),
      mk(FN_SET_LEVEL, 3, 4, 0, 8'hFF, 0),
      mk(FN_SET_MONO, 2, 0, 0, 255, 0),
      mk(FN_SET_MONO, 5, 6, 0, 16, 0),
      mk(FN_SET_MONO, 6, 6, 0, 0, 0),
      mk(FN_REFRESH, 0, 0, 0, 0, 0),
      mk(FN_NOP, 7, 7, 24'hFFFFFF, 255, 32'hFFFFFFFF),
      mk(FN_TICK, 0, 0, 0, 0, 1234),
      mk(FN_PULSE, 0, 0, 0, 0, 32'hFFFFFFF0),
      mk(FN_TICK, 0, 0, 0, 0, 32'h00000005),
      mk(FN_TICK, 0, 0, 0, 0, 32'hFFFFFFF0 + 999),
      mk(FN_TICK, 0, 0, 0, 0, 32'hFFFFFFF0 + 1999),
      mk(FN_TICK, 0, 0, 0, 0, 32'hFFFFFFF0 + 2499),
      mk(FN_REFRESH, 0, 0, 0, 0, 0),
      mk(FN_ALL_MONO, 0, 0, 0, 0, 0),
      mk(FN_REFRESH, 0, 0, 0, 0, 0, 1, 24'h000000)
    };
    foreach (dir_tab[i]) send_cmd(dir_tab[i]);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_ROWS, phase_cfg[ph][0]);
      write_reg(CFG_COLS, phase_cfg[ph][1]);
      write_reg(CFG_PERIOD, phase_cfg[ph][2]);
      now_ms = $urandom;
      send_cmd(mk(FN_PULSE, 0, 0, 0, 0, now_ms));
      for (int n = 0; n < 19; n++) begin
        if (ph == 2 && n == 9) begin
          // hold the sender until the block has delivered everything
          @(negedge clk_i);
          in_valid_i = 1'b0;
          while (pixel_q.size() != 0) @(posedge clk_i);
        end
        send_cmd(random_cmd());
      end
      wait_idle();
    end

    $display("sent %0d commands over 10 grid and period settings, checked %0d pixels",
             items_sent, pixels_seen);
    if (fail_cnt == 0) $display("led_grid_dimmer_rainbow_pulse_top_tb OK");
    else $display("led_grid_dimmer_rainbow_pulse_top_tb NOT OK");
    $finish;
  end

endmodule
